@@ rtl/abst_pkg.sv @@
// Package for the array binary search tree: sizes, codes and the structs
// shared by the level cells, the level memories and the top level.
// Depends on nothing.
package abst_pkg;

   // Store size and derived tree shape.
   localparam int NODE_COUNT = 255;
   localparam int LEVELS     = $clog2(NODE_COUNT + 1);
   localparam int IDX_W      = LEVELS;
   localparam int KEY_W      = 8;
   localparam int POS_W      = 8;

   // Operation codes.
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   // Status codes: insert ok / search found, insert full / search not found.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      op_type                   operation;
      logic signed [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [POS_W-1:0]  position;
   } rsp_type;

   // Transaction walking down the row of level cells.
   typedef struct packed {
      logic                     live;
      logic                     done;
      op_type                   operation;
      logic signed [KEY_W-1:0]  key;
      logic [IDX_W-1:0]         idx;
      logic                     status;
      logic [POS_W-1:0]         position;
   } token_type;

   // Write request from a level cell into its level memory.
   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         idx;
      logic signed [KEY_W-1:0]  key;
   } wr_req_type;

   // Low bits of a node index, as reported in the position field.
   function automatic logic [POS_W-1:0] to_position(input logic [IDX_W-1:0] idx);
      logic [IDX_W+POS_W-1:0] wide;
      wide = {{POS_W{1'b0}}, idx};
      return wide[POS_W-1:0];
   endfunction

endpackage

@@ rtl/abst_level_ram.sv @@
// Node memory of one tree level, with a valid bit per entry cleared at reset.
// Depends on abst_pkg.
module abst_level_ram #(
   parameter int LEVEL = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [abst_pkg::IDX_W-1:0]        wr_idx,
   input  logic signed [abst_pkg::KEY_W-1:0] wr_key,
   input  logic [abst_pkg::IDX_W-1:0]        rd_idx,
   output logic signed [abst_pkg::KEY_W-1:0] rd_key
);
   import abst_pkg::*;

   localparam int DEPTH  = 1 << LEVEL;
   localparam int ADDR_W = (LEVEL == 0) ? 1 : LEVEL;
   localparam logic [IDX_W:0] BASE = (IDX_W + 1)'(DEPTH - 1);

   logic signed [KEY_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]        vld_ff;
   logic [DEPTH-1:0]        vld_in;
   logic signed [KEY_W-1:0] rd_data_ff;
   logic                    rd_vld_ff;
   logic [IDX_W:0]          wr_ofs;
   logic [IDX_W:0]          rd_ofs;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ADDR_W-1:0]       rd_addr;

   // Offset of a node inside this level.
   assign wr_ofs  = {1'b0, wr_idx} - BASE;
   assign rd_ofs  = {1'b0, rd_idx} - BASE;
   assign wr_addr = wr_ofs[ADDR_W-1:0];
   assign rd_addr = rd_ofs[ADDR_W-1:0];

   // Data array with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_key;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // Valid bits: an entry never written reads as empty.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_key = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ rtl/abst_cell.sv @@
// One level cell: holds the transaction visiting its tree level, decides the
// step at that level and hands the transaction to the next level.
// Depends on abst_pkg.
module abst_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  abst_pkg::token_type               tok_i,
   input  logic signed [abst_pkg::KEY_W-1:0] node_key,
   output abst_pkg::token_type               tok_o,
   output abst_pkg::wr_req_type              wr_o
);
   import abst_pkg::*;

   localparam logic [IDX_W:0] NODE_LIMIT = (IDX_W + 1)'(NODE_COUNT);

   token_type       tok_ff;
   logic            go_left;
   logic [IDX_W:0]  child;

   // Transaction register; only the live flag needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff.live <= tok_i.live;
      end
      tok_ff.done      <= tok_i.done;
      tok_ff.operation <= tok_i.operation;
      tok_ff.key       <= tok_i.key;
      tok_ff.idx       <= tok_i.idx;
      tok_ff.status    <= tok_i.status;
      tok_ff.position  <= tok_i.position;
   end

   // Branch direction and child index; equal keys go left on insert.
   always_comb begin
      if (tok_ff.operation == OP_INSERT) begin
         go_left = (tok_ff.key <= node_key);
      end else begin
         go_left = (tok_ff.key < node_key);
      end
      child = {tok_ff.idx, 1'b0} + (go_left ? (IDX_W + 1)'(1) : (IDX_W + 1)'(2));
   end

   // Step at this level.
   always_comb begin
      tok_o = tok_ff;
      wr_o  = '0;
      if (tok_ff.live && !tok_ff.done) begin
         if (node_key == '0) begin
            // Empty node: insert stores here, search misses.
            tok_o.done = 1'b1;
            if (tok_ff.operation == OP_INSERT) begin
               wr_o.en          = 1'b1;
               wr_o.idx         = tok_ff.idx;
               wr_o.key         = tok_ff.key;
               tok_o.status     = STATUS_OK;
               tok_o.position   = to_position(tok_ff.idx);
            end else begin
               tok_o.status     = STATUS_FAIL;
               tok_o.position   = '0;
            end
         end else if (tok_ff.operation == OP_SEARCH && node_key == tok_ff.key) begin
            tok_o.done     = 1'b1;
            tok_o.status   = STATUS_OK;
            tok_o.position = to_position(tok_ff.idx);
         end else if (child >= NODE_LIMIT) begin
            // Walk leaves the store: full on insert, not found on search.
            tok_o.done     = 1'b1;
            tok_o.status   = STATUS_FAIL;
            tok_o.position = '0;
         end else begin
            tok_o.idx = child[IDX_W-1:0];
         end
      end
   end

endmodule

@@ rtl/array_bst_insert_search_top.sv @@
// Binary search tree of signed 8-bit keys stored as an implicit array, built
// as a row of level cells and level memories. Depends on abst_pkg,
// abst_cell and abst_level_ram.
//
// A transaction enters the cell of the root level and moves down one tree
// level per clock, each cell reading the node memory of its own level, so the
// result passes the transaction register of every level cell and then the
// output register. One transaction is in the tree at a time: a new request
// is taken once the busy register clears after the previous one leaves the
// last level, and only while the skid register is empty. A finished result
// may wait in the output register and one skid register while the next
// transaction walks the tree. The node store is empty after reset with no
// clearing pass; a node holding zero counts as empty, so inserting key zero
// reports its position but leaves the node reading as empty.
module array_bst_insert_search_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  abst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output abst_pkg::rsp_type rsp_data
);
   import abst_pkg::*;

   token_type               tok_in   [LEVELS];
   token_type               tok_out  [LEVELS];
   wr_req_type              wr_req   [LEVELS];
   logic signed [KEY_W-1:0] node_key [LEVELS];

   logic    busy_ff, busy_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    hold_valid_ff, hold_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type hold_data_ff, hold_data_in;
   logic    req_accept;
   logic    rsp_accept;
   logic    tok_exit;
   rsp_type tok_rsp;

   assign req_ready  = !busy_ff && !hold_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid_ff && rsp_ready;

   // New transaction enters the root level.
   always_comb begin
      tok_in[0]           = '0;
      tok_in[0].live      = req_accept;
      tok_in[0].operation = req_data.operation;
      tok_in[0].key       = req_data.key;
      tok_in[0].status    = STATUS_FAIL;
   end

   // Row of level cells, each with the node memory of its level.
   for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
      if (lv > 0) begin : g_link
         assign tok_in[lv] = tok_out[lv-1];
      end

      abst_level_ram #(
         .LEVEL (lv)
      ) u_ram (
         .clock  (clock),
         .reset  (reset),
         .wr_en  (wr_req[lv].en),
         .wr_idx (wr_req[lv].idx),
         .wr_key (wr_req[lv].key),
         .rd_idx (tok_in[lv].idx),
         .rd_key (node_key[lv])
      );

      abst_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (tok_in[lv]),
         .node_key (node_key[lv]),
         .tok_o    (tok_out[lv]),
         .wr_o     (wr_req[lv])
      );
   end

   assign tok_exit         = tok_out[LEVELS-1].live;
   assign tok_rsp.status   = tok_out[LEVELS-1].status;
   assign tok_rsp.position = tok_out[LEVELS-1].position;

   // Busy while a transaction walks the tree.
   always_comb begin
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (tok_exit) begin
         busy_in = 1'b0;
      end
   end

   // Output register with one skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (rsp_accept) begin
         rsp_valid_in  = hold_valid_ff;
         rsp_data_in   = hold_data_ff;
         hold_valid_in = 1'b0;
      end
      if (tok_exit) begin
         if (rsp_valid_in) begin
            hold_valid_in = 1'b1;
            hold_data_in  = tok_rsp;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = tok_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
